// File: rtl/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared widths, register indexes, pipeline types and the divider step for
// the depth-to-point back-projection block.
// ----------------------------------------------------------------------------
package dtpb_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned FRAME_W    = 13;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned NUM_W      = 36;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CAL_W-1:0] DEFAULT_FOCAL16 = 16'd8400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X        = 4'd0,
    REG_FOCAL_Y        = 4'd1,
    REG_CENTRE_X       = 4'd2,
    REG_CENTRE_Y       = 4'd3,
    REG_FOCAL_OVERRIDE = 4'd4,
    REG_USE_DEFAULT    = 4'd5,
    REG_FRAME_WIDTH    = 4'd6,
    REG_FRAME_HEIGHT   = 4'd7
  } dtpb_reg_e;

  // effective calibration after override and default selection
  typedef struct packed {
    logic [CAL_W-1:0] fx;
    logic [CAL_W-1:0] fy;
    logic [CAL_W-1:0] cx;
    logic [CAL_W-1:0] cy;
  } dtpb_calib_t;

  // per-request data that rides alongside the arithmetic
  typedef struct packed {
    logic               point_valid;
    logic               neg_x;
    logic               neg_y;
    logic [DEPTH_W-1:0] z;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } dtpb_side_t;

  // one divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [NUM_W-1:0] work;
  } dtpb_div_t;

  // DIV_BITS restoring division steps, quotient bits shift in at the bottom
  function automatic dtpb_div_t div_steps(dtpb_div_t s, logic [CAL_W-1:0] den);
    logic [MAG_W:0]   trial;
    logic [MAG_W-1:0] rem;
    logic [NUM_W-1:0] work;
    dtpb_div_t        res;
    rem  = s.rem;
    work = s.work;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem, work[NUM_W-1]};
      work  = {work[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial   = trial - {1'b0, den};
        work[0] = 1'b1;
      end
      rem = trial[MAG_W-1:0];
    end
    res.rem  = rem;
    res.work = work;
    return res;
  endfunction

endpackage

// File: rtl/dtpb_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtpb_cfg_regs
// Configuration register file and effective calibration selection.
// ----------------------------------------------------------------------------
module dtpb_cfg_regs import dtpb_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output dtpb_calib_t           calib_o
);

  localparam logic [FRAME_W-1:0] W_LIMIT = FRAME_W'(MAX_COLUMNS);
  localparam logic [FRAME_W-1:0] H_LIMIT = FRAME_W'(MAX_ROWS);

  logic [CAL_W-1:0]   focal_x_q, focal_y_q, centre_x_q, centre_y_q, override_q;
  logic               use_default_q;
  logic [FRAME_W-1:0] frame_w_q, frame_h_q;
  logic [FRAME_W-1:0] w_clamp, h_clamp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q     <= 16'd8400;
      focal_y_q     <= 16'd8400;
      centre_x_q    <= 16'd5120;
      centre_y_q    <= 16'd3840;
      override_q    <= '0;
      use_default_q <= 1'b0;
      frame_w_q     <= 13'd640;
      frame_h_q     <= 13'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FOCAL_X:        focal_x_q     <= cfg_data_i;
        REG_FOCAL_Y:        focal_y_q     <= cfg_data_i;
        REG_CENTRE_X:       centre_x_q    <= cfg_data_i;
        REG_CENTRE_Y:       centre_y_q    <= cfg_data_i;
        REG_FOCAL_OVERRIDE: override_q    <= cfg_data_i;
        REG_USE_DEFAULT:    use_default_q <= cfg_data_i[0];
        REG_FRAME_WIDTH:    frame_w_q     <= cfg_data_i[FRAME_W-1:0];
        REG_FRAME_HEIGHT:   frame_h_q     <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_clamp    = (frame_w_q > W_LIMIT) ? W_LIMIT : frame_w_q;
    h_clamp    = (frame_h_q > H_LIMIT) ? H_LIMIT : frame_h_q;
    calib_o.fx = (override_q != '0) ? override_q : focal_x_q;
    calib_o.fy = (override_q != '0) ? override_q : focal_y_q;
    calib_o.cx = centre_x_q;
    calib_o.cy = centre_y_q;
    if (use_default_q) begin
      calib_o.fx = DEFAULT_FOCAL16;
      calib_o.fy = DEFAULT_FOCAL16;
      calib_o.cx = {w_clamp[FRAME_W-1:1], 4'b0};
      calib_o.cy = {h_clamp[FRAME_W-1:1], 4'b0};
    end
    // a zero focal length divides by one
    if (calib_o.fx == '0) calib_o.fx = CAL_W'(1);
    if (calib_o.fy == '0) calib_o.fy = CAL_W'(1);
  end

endmodule

// File: rtl/dtpb_premul.sv
// ----------------------------------------------------------------------------
// dtpb_premul
// Index clamp, centre offset and magnitude multiply by depth, two stages.
// ----------------------------------------------------------------------------
module dtpb_premul import dtpb_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtpb_calib_t        calib_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] column_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic [COLOR_W-1:0] blue_i,
  input  logic [COLOR_W-1:0] green_i,
  input  logic [COLOR_W-1:0] red_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [NUM_W-1:0]   num_x_o,
  output logic [NUM_W-1:0]   num_y_o,
  output dtpb_side_t         side_o
);

  localparam logic [COORD_W-1:0] COL_LIMIT = COORD_W'(MAX_COLUMNS - 1);
  localparam logic [COORD_W-1:0] ROW_LIMIT = COORD_W'(MAX_ROWS - 1);

  logic               v1_q, v2_q, rdy1, rdy2;
  logic [DIFF_W-1:0]  dx_q, dy_q, dx_d, dy_d;
  dtpb_side_t         s1_q, s1_d, s2_q, s2_d;
  logic [COORD_W-1:0] col_c, row_c;
  logic [DIFF_W-1:0]  ax, ay;
  logic [PROD_W-1:0]  px, py;
  logic [NUM_W-1:0]   nx_q, ny_q;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    col_c             = (column_i > COL_LIMIT) ? COL_LIMIT : column_i;
    row_c             = (row_i > ROW_LIMIT) ? ROW_LIMIT : row_i;
    dx_d              = {1'b0, col_c, 4'b0} - {1'b0, calib_i.cx};
    dy_d              = {1'b0, row_c, 4'b0} - {1'b0, calib_i.cy};
    s1_d.point_valid  = (depth_mm_i != '0);
    s1_d.neg_x        = dx_d[DIFF_W-1];
    s1_d.neg_y        = dy_d[DIFF_W-1];
    s1_d.z            = depth_mm_i;
    s1_d.blue         = blue_i;
    s1_d.green        = green_i;
    s1_d.red          = red_i;
  end

  // magnitude fits in 16 bits, the sign rides in the side struct
  always_comb begin
    ax   = dx_q[DIFF_W-1] ? (~dx_q + DIFF_W'(1)) : dx_q;
    ay   = dy_q[DIFF_W-1] ? (~dy_q + DIFF_W'(1)) : dy_q;
    px   = PROD_W'(ax[MAG_W-1:0]) * PROD_W'(s1_q.z);
    py   = PROD_W'(ay[MAG_W-1:0]) * PROD_W'(s1_q.z);
    s2_d = s1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      nx_q <= {px, 4'b0};
      ny_q <= {py, 4'b0};
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign num_x_o     = nx_q;
  assign num_y_o     = ny_q;
  assign side_o      = s2_q;

endmodule

// File: rtl/dtpb_divider.sv
// ----------------------------------------------------------------------------
// dtpb_divider
// Pipelined restoring divider, two lanes, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module dtpb_divider import dtpb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtpb_calib_t      calib_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NUM_W-1:0] num_x_i,
  input  logic [NUM_W-1:0] num_y_i,
  input  dtpb_side_t       side_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [NUM_W-1:0] quo_x_o,
  output logic [NUM_W-1:0] quo_y_o,
  output dtpb_side_t       side_o
);

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] v_q, rdy, src_v;
  dtpb_div_t             lx_q   [DIV_STAGES];
  dtpb_div_t             ly_q   [DIV_STAGES];
  dtpb_side_t            sd_q   [DIV_STAGES];
  dtpb_div_t             lx_d   [DIV_STAGES];
  dtpb_div_t             ly_d   [DIV_STAGES];
  dtpb_side_t            sd_d   [DIV_STAGES];
  dtpb_div_t             src_x, src_y;

  always_comb begin
    rdy[LAST] = !v_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        src_v[k]   = in_valid_i;
        src_x.rem  = '0;
        src_x.work = num_x_i;
        src_y.rem  = '0;
        src_y.work = num_y_i;
        sd_d[k]    = side_i;
      end else begin
        src_v[k] = v_q[k-1];
        src_x    = lx_q[k-1];
        src_y    = ly_q[k-1];
        sd_d[k]  = sd_q[k-1];
      end
      lx_d[k] = div_steps(src_x, calib_i.fx);
      ly_d[k] = div_steps(src_y, calib_i.fy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) v_q[k] <= src_v[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && src_v[k]) begin
        lx_q[k] <= lx_d[k];
        ly_q[k] <= ly_d[k];
        sd_q[k] <= sd_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[LAST];
  assign quo_x_o     = lx_q[LAST].work;
  assign quo_y_o     = ly_q[LAST].work;
  assign side_o      = sd_q[LAST];

endmodule

// File: rtl/dtpb_post.sv
// ----------------------------------------------------------------------------
// dtpb_post
// Sign restore, 32-bit saturation, invalid-point zeroing and output register.
// ----------------------------------------------------------------------------
module dtpb_post import dtpb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NUM_W-1:0]   quo_x_i,
  input  logic [NUM_W-1:0]   quo_y_i,
  input  dtpb_side_t         side_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               point_valid_o,
  output logic [POS_W-1:0]   pos_x_o,
  output logic [POS_W-1:0]   pos_y_o,
  output logic [DEPTH_W-1:0] pos_z_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] red_o
);

  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(36'h07FFFFFFF);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(36'h080000000);
  localparam logic [POS_W-1:0] S32_MAX = 32'h7FFFFFFF;
  localparam logic [POS_W-1:0] S32_MIN = 32'h80000000;

  logic               v_q, rdy;
  logic               pv_q;
  logic [POS_W-1:0]   x_q, y_q, x_d, y_d;
  logic [DEPTH_W-1:0] z_q;
  logic [COLOR_W-1:0] b_q, g_q, r_q;
  logic               pv;

  function automatic logic [POS_W-1:0] sat_signed(logic [NUM_W-1:0] q, logic neg);
    logic [POS_W-1:0] res;
    if (neg) begin
      res = (q > NEG_LIM) ? S32_MIN : (~q[POS_W-1:0] + POS_W'(1));
    end else begin
      res = (q > POS_LIM) ? S32_MAX : q[POS_W-1:0];
    end
    return res;
  endfunction

  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;
  assign pv         = side_i.point_valid;

  always_comb begin
    x_d = pv ? sat_signed(quo_x_i, side_i.neg_x) : '0;
    y_d = pv ? sat_signed(quo_y_i, side_i.neg_y) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      pv_q <= pv;
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= pv ? side_i.z : '0;
      b_q  <= pv ? side_i.blue : '0;
      g_q  <= pv ? side_i.green : '0;
      r_q  <= pv ? side_i.red : '0;
    end
  end

  assign out_valid_o   = v_q;
  assign point_valid_o = pv_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign pos_z_o       = z_q;
  assign blue_o        = b_q;
  assign green_o       = g_q;
  assign red_o         = r_q;

endmodule

// File: rtl/depth_to_point_backproject.sv
// ----------------------------------------------------------------------------
// depth_to_point_backproject
// Pinhole back-projection of a depth pixel stream into 3D points.
// ----------------------------------------------------------------------------
// Each request carries one depth pixel (column, row, depth in mm, colour) and
// gives one point: x = (col*16 - cx) * z * 16 / fx and y likewise, truncated
// toward zero and saturated to signed 32 bits, in 1/16 mm. A zero depth gives
// an all-zero result. The block accepts one request per clock and delivers
// one result per clock while the output side takes them. The path from
// input request to output valid holds two stages for offset and multiply,
// nine stages of a radix-16 restoring divider (four quotient bits per
// stage, 36 bits in all) and one output register for saturation. Any
// stage holding a bubble keeps accepting while later stages stall.
// Configuration writes are always taken and must only be issued while the
// pipeline is empty.
module depth_to_point_backproject import dtpb_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_W-1:0]    column_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [DEPTH_W-1:0]    depth_mm_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  // point result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  point_valid_o,
  output logic [POS_W-1:0]      pos_x_o,
  output logic [POS_W-1:0]      pos_y_o,
  output logic [DEPTH_W-1:0]    pos_z_o,
  output logic [COLOR_W-1:0]    blue_out_o,
  output logic [COLOR_W-1:0]    green_out_o,
  output logic [COLOR_W-1:0]    red_out_o
);

  // effective calibration; the user must keep it stable while requests are in flight, the block does not enforce it
  dtpb_calib_t      calib;

  // premultiply -> divider
  logic             pm_valid, pm_ready;
  logic [NUM_W-1:0] pm_num_x, pm_num_y;
  dtpb_side_t       pm_side;

  // divider -> output stage
  logic             dv_valid, dv_ready;
  logic [NUM_W-1:0] dv_quo_x, dv_quo_y;
  dtpb_side_t       dv_side;

  dtpb_cfg_regs #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .calib_o    (calib)
  );

  // clamp, centre offset, |offset| * depth
  dtpb_premul #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_premul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .calib_i    (calib),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .column_i   (column_i),
    .row_i      (row_i),
    .depth_mm_i (depth_mm_i),
    .blue_i     (blue_in_i),
    .green_i    (green_in_i),
    .red_i      (red_in_i),
    .out_valid_o(pm_valid),
    .out_ready_i(pm_ready),
    .num_x_o    (pm_num_x),
    .num_y_o    (pm_num_y),
    .side_o     (pm_side)
  );

  // magnitude divide by focal length, both axes side by side
  dtpb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .calib_i    (calib),
    .in_valid_i (pm_valid),
    .in_ready_o (pm_ready),
    .num_x_i    (pm_num_x),
    .num_y_i    (pm_num_y),
    .side_i     (pm_side),
    .out_valid_o(dv_valid),
    .out_ready_i(dv_ready),
    .quo_x_o    (dv_quo_x),
    .quo_y_o    (dv_quo_y),
    .side_o     (dv_side)
  );

  // sign, saturation, invalid zeroing, output register
  dtpb_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dv_valid),
    .in_ready_o   (dv_ready),
    .quo_x_i      (dv_quo_x),
    .quo_y_i      (dv_quo_y),
    .side_i       (dv_side),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_valid_o(point_valid_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .blue_o       (blue_out_o),
    .green_o      (green_out_o),
    .red_o        (red_out_o)
  );

  // divider never sees a zero divisor
  a_focal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (calib.fx != '0) && (calib.fy != '0))
    else $error("effective focal length is zero");

  // a valid point always carries its nonzero depth
  a_valid_has_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_valid_o) |-> (pos_z_o != '0))
    else $error("valid point with zero depth");

  // an invalid point is all zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !point_valid_o) |->
      ((pos_x_o == '0) && (pos_y_o == '0) && (pos_z_o == '0) &&
       (blue_out_o == '0) && (green_out_o == '0) && (red_out_o == '0)))
    else $error("invalid point with nonzero fields");

  // a full output register that is not taken blocks the divider hand-off
  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !dv_ready)
    else $error("output register overwritten while stalled");

endmodule
